### rtl/core/tsa_pkg.sv
// Shared types, constants and the control store of the sine series engine.
package tsa_pkg;

  // Series limits and fixed-point format.
  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int ARG_W = 21;
  localparam int CNT_W = 5;
  localparam int SUM_W = 48;
  localparam int MAG_W = 48;
  localparam int K_W   = $clog2(MAX_TERMS);

  // Datapath widths: x squared, reciprocal constants, ratio r(k).
  localparam int X2_W  = 2 * ARG_W - FRAC_BITS - 1;
  localparam int RCP_W = 30;
  localparam int R_W   = 22;

  // The term product is split into a high and a low half at this bit.
  localparam int SPLIT = 24;
  localparam int HI_W  = MAG_W - SPLIT;
  // High partial products at or above 2^HP_W always overflow the term.
  localparam int HP_W  = MAG_W - 1 - (SPLIT - FRAC_BITS);

  // Shared multiplier.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // round(2^32 / ((2k+2)(2k+3))) for each term index k.
  localparam logic [RCP_W-1:0] RECIP [MAX_TERMS] = '{
    30'd715827883, 30'd214748365, 30'd102261126, 30'd59652324,
    30'd39045157,  30'd27531842,  30'd20452225,  30'd15790321,
    30'd12558384,  30'd10226113,  30'd8488078,   30'd7158279,
    30'd6118187,   30'd5289369,   30'd4618244,   30'd4067204
  };

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_RCP,
    MUL_HI,
    MUL_LO
  } mul_sel_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_IN,
    JC_LAST,
    JC_OUT_BUSY
  } jcond_t;

  // Program steps; the address of each step in the control store.
  typedef enum logic [3:0] {
    ST_OUT,
    ST_WAIT,
    ST_SQ,
    ST_X2,
    ST_ACC,
    ST_RMUL,
    ST_RND,
    ST_HMUL,
    ST_LMUL,
    ST_TERM
  } step_t;

  // One control word.
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     take_in;
    logic     ld_x2;
    logic     acc;
    logic     ld_r;
    logic     ld_hp;
    logic     ld_term;
    logic     give_out;
    jcond_t   jcond;
    step_t    target;
  } ctrl_t;

  // Status fed back from the datapath to the sequencer.
  typedef struct packed {
    logic last;
    logic out_busy;
  } flags_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      ST_OUT: begin
        w.give_out = 1'b1;
        w.jcond    = JC_OUT_BUSY;
        w.target   = ST_OUT;
      end
      ST_WAIT: begin
        w.take_in = 1'b1;
        w.jcond   = JC_NO_IN;
        w.target  = ST_WAIT;
      end
      ST_SQ: begin
        w.mul_sel = MUL_SQ;
      end
      ST_X2: begin
        w.ld_x2 = 1'b1;
      end
      ST_ACC: begin
        w.acc    = 1'b1;
        w.jcond  = JC_LAST;
        w.target = ST_OUT;
      end
      ST_RMUL: begin
        w.mul_sel = MUL_RCP;
      end
      ST_RND: begin
        w.ld_r = 1'b1;
      end
      ST_HMUL: begin
        w.mul_sel = MUL_HI;
      end
      ST_LMUL: begin
        w.mul_sel = MUL_LO;
        w.ld_hp   = 1'b1;
      end
      ST_TERM: begin
        w.ld_term = 1'b1;
        w.jcond   = JC_ALWAYS;
        w.target  = ST_ACC;
      end
      default: begin
        w.jcond  = JC_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/tsa_mul.sv
// Shared unsigned multiplier with a registered product.
module tsa_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tsa_pkg::MUL_W-1:0]   op_a,
  input  logic [tsa_pkg::MUL_W-1:0]   op_b,
  output logic [tsa_pkg::PROD_W-1:0]  prod
);

  logic [tsa_pkg::PROD_W-1:0] prod_r;

  // The product holds until the next issued multiplication.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/core/tsa_seq.sv
// Step counter and control store of the series engine.
module tsa_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tsa_pkg::flags_t flags,
  output tsa_pkg::ctrl_t  ctrl
);

  tsa_pkg::step_t pc_r;
  tsa_pkg::step_t pc_nxt;
  logic           jump;

  // Control word of the current step.
  always_comb begin
    ctrl = tsa_pkg::ucode(pc_r);
  end

  // Next step: jump to the target when the condition holds, else advance.
  always_comb begin
    unique case (ctrl.jcond)
      tsa_pkg::JC_NEXT:     jump = 1'b0;
      tsa_pkg::JC_ALWAYS:   jump = 1'b1;
      tsa_pkg::JC_NO_IN:    jump = !in_valid;
      tsa_pkg::JC_LAST:     jump = flags.last;
      tsa_pkg::JC_OUT_BUSY: jump = flags.out_busy;
      default:              jump = 1'b1;
    endcase
    if (jump) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = tsa_pkg::step_t'(pc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tsa_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### rtl/core/tsa_datapath.sv
// Registers, operand selection and result register of the series engine.
module tsa_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsa_pkg::ctrl_t                    ctrl,
  input  logic                              in_valid,
  input  logic signed [tsa_pkg::ARG_W-1:0]  in_arg_x,
  input  logic [tsa_pkg::CNT_W-1:0]         term_count,
  input  logic                              out_stall,
  output tsa_pkg::flags_t                   flags,
  output logic                              out_valid,
  output logic signed [tsa_pkg::SUM_W-1:0]  out_series_sum,
  output logic                              out_saturated
);

  localparam int ARG_W  = tsa_pkg::ARG_W;
  localparam int MAG_W  = tsa_pkg::MAG_W;
  localparam int SUM_W  = tsa_pkg::SUM_W;
  localparam int MUL_W  = tsa_pkg::MUL_W;
  localparam int PROD_W = tsa_pkg::PROD_W;
  localparam int X2_W   = tsa_pkg::X2_W;
  localparam int R_W    = tsa_pkg::R_W;
  localparam int HP_W   = tsa_pkg::HP_W;
  localparam int SPLIT  = tsa_pkg::SPLIT;
  localparam int FRAC   = tsa_pkg::FRAC_BITS;
  localparam int SQ_W   = 2 * ARG_W;

  logic [ARG_W-1:0]          mag_r;
  logic [X2_W-1:0]           x2_r;
  logic [R_W-1:0]            r_r;
  logic [HP_W-1:0]           hp_r;
  logic                      hp_ovf_r;
  logic [MAG_W-1:0]          tmag_r;
  logic                      tneg_r;
  logic [SUM_W-1:0]          sum_r;
  logic                      clip_r;
  logic [tsa_pkg::K_W-1:0]   k_r;
  logic [tsa_pkg::CNT_W-1:0] n_r;
  logic                      out_valid_r;
  logic [SUM_W-1:0]          series_sum_r;
  logic                      saturated_r;

  logic [ARG_W-1:0]  arg_u;
  logic [ARG_W-1:0]  mag_nxt;
  logic              take;
  logic              out_ld;
  logic              mul_en;
  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq_rnd;
  logic [PROD_W-1:0] r_rnd;
  logic [PROD_W-1:0] q_full;
  logic [MAG_W-1:0]  q;
  logic              term_clip;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W:0]    term_ext;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_nxt;
  logic              sum_clip;

  // Argument magnitude; the most negative argument still fits unsigned.
  assign arg_u   = in_arg_x;
  assign mag_nxt = arg_u[ARG_W-1] ? ((~arg_u) + ARG_W'(1)) : arg_u;

  assign take   = ctrl.take_in && in_valid;
  assign out_ld = ctrl.give_out && !flags.out_busy;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    case (ctrl.mul_sel)
      tsa_pkg::MUL_SQ: begin
        op_a = {{(MUL_W-ARG_W){1'b0}}, mag_r};
        op_b = {{(MUL_W-ARG_W){1'b0}}, mag_r};
      end
      tsa_pkg::MUL_RCP: begin
        op_a = {{(MUL_W-X2_W){1'b0}}, x2_r};
        op_b = {{(MUL_W-tsa_pkg::RCP_W){1'b0}}, tsa_pkg::RECIP[k_r]};
      end
      tsa_pkg::MUL_HI: begin
        op_a = {{(MUL_W-tsa_pkg::HI_W){1'b0}}, tmag_r[MAG_W-1:SPLIT]};
        op_b = {{(MUL_W-R_W){1'b0}}, r_r};
      end
      tsa_pkg::MUL_LO: begin
        op_a = {{(MUL_W-SPLIT){1'b0}}, tmag_r[SPLIT-1:0]};
        op_b = {{(MUL_W-R_W){1'b0}}, r_r};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  tsa_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Rounded x squared and rounded ratio r(k).
  assign sq_rnd = prod[SQ_W-1:0] + (SQ_W'(1) << (FRAC - 1));
  assign r_rnd  = prod + (PROD_W'(1) << 31);

  // Next term magnitude: the high partial product shifted into place, the
  // rounding constant in its empty low bits, plus the low partial product.
  assign q_full = {{(PROD_W-HP_W-SPLIT){1'b0}}, hp_r, SPLIT'(1) << (FRAC - 1)}
                + {{(PROD_W-MAG_W){1'b0}}, prod[MAG_W-1:0]};
  assign q         = q_full[FRAC +: MAG_W];
  assign term_clip = hp_ovf_r || q[MAG_W-1];

  // Signed accumulation with clipping to the result range.
  always_comb begin
    sum_ext  = {sum_r[SUM_W-1], sum_r};
    term_ext = {1'b0, tmag_r};
    sum_add  = tneg_r ? (sum_ext - term_ext) : (sum_ext + term_ext);
    sum_clip = 1'b0;
    if (!sum_add[SUM_W] && sum_add[SUM_W-1]) begin
      sum_nxt  = tsa_pkg::SUM_MAX;
      sum_clip = 1'b1;
    end else if (sum_add[SUM_W] && !sum_add[SUM_W-1]) begin
      sum_nxt  = tsa_pkg::SUM_MIN;
      sum_clip = 1'b1;
    end else begin
      sum_nxt = sum_add[SUM_W-1:0];
    end
  end

  // Status for the sequencer.
  assign flags.last     = ({1'b0, k_r} + tsa_pkg::CNT_W'(1)) == n_r;
  assign flags.out_busy = out_valid_r && out_stall;

  // Working registers of the item in progress.
  always_ff @(posedge clk) begin
    if (take) begin
      mag_r  <= mag_nxt;
      tmag_r <= {{(MAG_W-ARG_W){1'b0}}, mag_nxt};
      tneg_r <= arg_u[ARG_W-1];
      sum_r  <= '0;
      clip_r <= 1'b0;
      k_r    <= '0;
      n_r    <= term_count;
    end
    if (ctrl.ld_x2) begin
      x2_r <= sq_rnd[FRAC +: X2_W];
    end
    if (ctrl.ld_r) begin
      r_r <= r_rnd[32 +: R_W];
    end
    if (ctrl.ld_hp) begin
      hp_r     <= prod[HP_W-1:0];
      hp_ovf_r <= |prod[PROD_W-1:HP_W];
    end
    if (ctrl.acc) begin
      sum_r <= sum_nxt;
      if (sum_clip) begin
        clip_r <= 1'b1;
      end
    end
    if (ctrl.ld_term) begin
      tmag_r <= term_clip ? tsa_pkg::MAG_MAX : q;
      tneg_r <= !tneg_r;
      k_r    <= k_r + tsa_pkg::K_W'(1);
      if (term_clip) begin
        clip_r <= 1'b1;
      end
    end
  end

  // Result register: frees the engine while the word waits to be taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      series_sum_r <= sum_r;
      saturated_r  <= clip_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_series_sum = series_sum_r;
  assign out_saturated  = saturated_r;

endmodule

### rtl/core/taylor_sine_approx.sv
// Truncated Maclaurin series of sine: takes a signed Q4.16 argument and returns the sum of
// the first term_count terms as a saturating signed Q31.16 word, with a flag set when a term
// or a partial sum was clipped. A term count of zero gives one term and counts above 16 give
// 16; the user writes the count through cfg_we/cfg_wdata while the block is idle; the block
// itself does not enforce this. A microcoded sequencer drives one shared 32 by 32 multiplier,
// which forms three products for every term after the first. The result sits in an output
// register, so the next argument is taken while the previous result waits; the engine holds
// only once a second result is ready and the first has still not been taken.
module taylor_sine_approx (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tsa_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tsa_pkg::ARG_W-1:0]  in_arg_x,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tsa_pkg::SUM_W-1:0]  out_series_sum,
  output logic                              out_saturated
);

  localparam int CNT_W = tsa_pkg::CNT_W;

  tsa_pkg::ctrl_t  ctrl;
  tsa_pkg::flags_t flags;

  logic [CNT_W-1:0] term_count_r;
  logic [CNT_W-1:0] term_count_nxt;

  // Term count register, held clamped to the supported range.
  always_comb begin
    if (cfg_wdata == '0) begin
      term_count_nxt = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(tsa_pkg::MAX_TERMS)) begin
      term_count_nxt = CNT_W'(tsa_pkg::MAX_TERMS);
    end else begin
      term_count_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      term_count_r <= term_count_nxt;
    end
  end

  // A word is taken only in the waiting step of the program.
  assign in_stall = !ctrl.take_in;

  tsa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  tsa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_valid       (in_valid),
    .in_arg_x       (in_arg_x),
    .term_count     (term_count_r),
    .out_stall      (out_stall),
    .flags          (flags),
    .out_valid      (out_valid),
    .out_series_sum (out_series_sum),
    .out_saturated  (out_saturated)
  );

  // An accepted word starts with squaring the argument.
  a_accept_squares: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (ctrl.mul_sel == tsa_pkg::MUL_SQ))
    else $error("accepted word not followed by the squaring step");

  // Every finished term is accumulated in the next step.
  a_term_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld_term |=> ctrl.acc)
    else $error("new term not accumulated");

  // The last accumulation hands over to the result step.
  a_last_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.acc && flags.last) |=> ctrl.give_out)
    else $error("last term not followed by the result step");

  // The result register is never loaded over a word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.give_out && out_valid && out_stall) |=> (ctrl.give_out && out_valid))
    else $error("result register overwritten while stalled");

endmodule
